[rtl/lzwe_pkg.sv]
// lzwe_pkg: shared constants, types and state codes of the lzw byte encoder
// used by every module in rtl/
package lzwe_pkg;

  localparam int DICT_CODES = 4096;
  localparam int CODE_W     = $clog2(DICT_CODES);
  localparam int NFC_W      = CODE_W + 1;
  localparam int ENTRY_W    = CODE_W + 8;
  localparam int OUT_CODE_W = 12;
  localparam int FIRST_FREE = 256;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_MISS,
    ST_FLUSH
  } back_state_t;

endpackage

[rtl/lzwe_front.sv]
// lzwe_front: two-entry request queue in front of the dictionary engine
// depends on lzwe_pkg
module lzwe_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_end_of_message,
  output logic                 q_valid,
  input  logic                 q_ready,
  output lzwe_pkg::item_t      q_item
);

  lzwe_pkg::item_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{data_byte: in_data_byte, end_of_message: in_end_of_message};
    end
  end

endmodule

[rtl/lzwe_back.sv]
// lzwe_back: dictionary engine, entry memory and scan sequencer
// depends on lzwe_pkg
module lzwe_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  lzwe_pkg::item_t               q_item,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [lzwe_pkg::CODE_W-1:0]   res_code,
  output logic                          res_last
);

  localparam int CW = lzwe_pkg::CODE_W;
  localparam int NW = lzwe_pkg::NFC_W;
  localparam logic [NW-1:0] NFC_RESET = NW'(lzwe_pkg::FIRST_FREE);
  localparam logic [NW-1:0] NFC_MAX   = NW'(lzwe_pkg::DICT_CODES);

  lzwe_pkg::back_state_t state_r, state_nxt;
  logic [CW-1:0] prefix_r, prefix_nxt;
  logic          pv_r, pv_nxt;
  logic [NW-1:0] nfc_r, nfc_nxt;
  logic [NW-1:0] idx_r, idx_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          eom_r, eom_nxt;

  logic [lzwe_pkg::ENTRY_W-1:0] mem [lzwe_pkg::DICT_CODES];
  logic [lzwe_pkg::ENTRY_W-1:0] rd_data_r;
  logic                         we;
  logic [NW-1:0]                idx_inc;

  assign idx_inc = idx_r + NW'(1);

  always_comb begin
    state_nxt  = state_r;
    prefix_nxt = prefix_r;
    pv_nxt     = pv_r;
    nfc_nxt    = nfc_r;
    idx_nxt    = idx_r;
    byte_nxt   = byte_r;
    eom_nxt    = eom_r;
    q_ready    = 1'b0;
    res_valid  = 1'b0;
    res_code   = prefix_r;
    res_last   = 1'b0;
    we         = 1'b0;
    case (state_r)
      lzwe_pkg::ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          byte_nxt = q_item.data_byte;
          eom_nxt  = q_item.end_of_message;
          if (!pv_r) begin
            prefix_nxt = CW'(q_item.data_byte);
            pv_nxt     = 1'b1;
            state_nxt  = lzwe_pkg::ST_FLUSH;
          end else if (nfc_r > NFC_RESET) begin
            idx_nxt   = NFC_RESET;
            state_nxt = lzwe_pkg::ST_READ;
          end else begin
            state_nxt = lzwe_pkg::ST_MISS;
          end
        end
      end
      lzwe_pkg::ST_READ: begin
        state_nxt = lzwe_pkg::ST_CMP;
      end
      lzwe_pkg::ST_CMP: begin
        if (rd_data_r == {prefix_r, byte_r}) begin
          prefix_nxt = idx_r[CW-1:0];
          state_nxt  = lzwe_pkg::ST_FLUSH;
        end else if (idx_inc < nfc_r) begin
          idx_nxt   = idx_inc;
          state_nxt = lzwe_pkg::ST_READ;
        end else begin
          state_nxt = lzwe_pkg::ST_MISS;
        end
      end
      lzwe_pkg::ST_MISS: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (nfc_r < NFC_MAX) begin
            we      = 1'b1;
            nfc_nxt = nfc_r + NW'(1);
          end
          prefix_nxt = CW'(byte_r);
          state_nxt  = lzwe_pkg::ST_FLUSH;
        end
      end
      lzwe_pkg::ST_FLUSH: begin
        if (eom_r) begin
          res_valid = 1'b1;
          res_last  = 1'b1;
          if (res_ready) begin
            prefix_nxt = '0;
            pv_nxt     = 1'b0;
            nfc_nxt    = NFC_RESET;
            state_nxt  = lzwe_pkg::ST_IDLE;
          end
        end else begin
          state_nxt = lzwe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lzwe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lzwe_pkg::ST_IDLE;
      prefix_r <= '0;
      pv_r     <= 1'b0;
      nfc_r    <= NFC_RESET;
    end else begin
      state_r  <= state_nxt;
      prefix_r <= prefix_nxt;
      pv_r     <= pv_nxt;
      nfc_r    <= nfc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    byte_r <= byte_nxt;
    eom_r  <= eom_nxt;
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[nfc_r[CW-1:0]] <= {prefix_r, byte_r};
    end
    rd_data_r <= mem[idx_r[CW-1:0]];
  end

endmodule

[rtl/lzwe_out_stage.sv]
// lzwe_out_stage: output register for emitted codes
// depends on lzwe_pkg
module lzwe_out_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          res_valid,
  output logic                          res_ready,
  input  logic [lzwe_pkg::CODE_W-1:0]   res_code,
  input  logic                          res_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [11:0]                   out_code_word,
  output logic                          out_last_code
);

  localparam int CW = lzwe_pkg::CODE_W;

  logic                  valid_r, valid_nxt;
  logic [11:0]           code_r;
  logic                  last_r;
  logic [CW+11:0]        code_ext;

  assign code_ext      = {12'b0, res_code};
  assign res_ready     = !valid_r || out_ready;
  assign out_valid     = valid_r;
  assign out_code_word = code_r;
  assign out_last_code = last_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res_ready) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      code_r <= code_ext[11:0];
      last_r <= res_last;
    end
  end

endmodule

[rtl/lzw_byte_encoder.sv]
// lzw_byte_encoder: top level of the lzw byte encoder
// depends on lzwe_pkg, lzwe_front, lzwe_back, lzwe_out_stage
//
// Bytes come in with an end-of-message flag and leave as dictionary codes,
// one code per dictionary miss and one flagged final code per message. A
// two-request queue takes bytes while the engine is busy. The engine handles
// one byte at a time: it classifies it in ST_IDLE and ST_FLUSH, passes
// through ST_MISS when it misses, and visits ST_READ then ST_CMP for each
// dictionary entry scanned, since the entry memory is scanned sequentially
// through its registered read port. No clearing pass is needed after reset
// or between messages.
module lzw_byte_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_code_word,
  output logic        out_last_code
);

  logic                        q_valid;
  logic                        q_ready;
  lzwe_pkg::item_t             q_item;
  logic                        res_valid;
  logic                        res_ready;
  logic [lzwe_pkg::CODE_W-1:0] res_code;
  logic                        res_last;

  lzwe_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_item            (q_item)
  );

  lzwe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_code  (res_code),
    .res_last  (res_last)
  );

  lzwe_out_stage u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_code      (res_code),
    .res_last      (res_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_code_word (out_code_word),
    .out_last_code (out_last_code)
  );

endmodule

[tb/lzw_byte_encoder_test.sv]
// lzw_byte_encoder_test: self-checking bench for the lzw byte encoder
// depends on lzwe_pkg and rtl/lzw_byte_encoder; a local dictionary model
// predicts each code, and the codes are checked in order against the block
`timescale 1ns / 1ps

module lzw_byte_encoder_test;

  localparam int CW = lzwe_pkg::CODE_W;
  localparam int OW = lzwe_pkg::OUT_CODE_W;

  typedef struct {
    logic [11:0] code_word;
    logic        last_code;
  } code_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] out_code_word;
  logic        out_last_code;

  lzw_byte_encoder u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_byte(in_data_byte),
    .in_end_of_message(in_end_of_message),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_code_word(out_code_word),
    .out_last_code(out_last_code)
  );

  logic [CW-1:0]     dict_prefix [lzwe_pkg::DICT_CODES];
  logic [7:0]        dict_byte [lzwe_pkg::DICT_CODES];
  logic [CW-1:0]     cur_prefix;
  logic              have_prefix;
  int unsigned       free_code;
  code_t             pending_codes [$];
  int                mismatch_count;
  int                burst_left;
  int                stall_mode = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("lzw_byte_encoder_test NOT OK");
    $finish;
  end

  function automatic void add_expected(code_t c);
    pending_codes = {pending_codes, c};
  endfunction

  // dictionary model of one accepted byte
  function automatic void encode_byte(logic [7:0] b, logic eom);
    int unsigned k;
    bit found;
    code_t c;
    found = 1'b0;
    if (!have_prefix) begin
      cur_prefix = CW'(b);
      have_prefix = 1'b1;
    end else begin
      for (k = lzwe_pkg::FIRST_FREE; k < free_code && !found; k++) begin
        if (dict_prefix[k] == cur_prefix && dict_byte[k] == b) begin
          cur_prefix = CW'(k);
          found = 1'b1;
        end
      end
      if (!found) begin
        c.code_word = OW'(cur_prefix);
        c.last_code = 1'b0;
        add_expected(c);
        if (free_code < lzwe_pkg::DICT_CODES) begin
          dict_prefix[free_code] = cur_prefix;
          dict_byte[free_code] = b;
          free_code++;
        end
        cur_prefix = CW'(b);
      end
    end
    if (eom) begin
      c.code_word = OW'(cur_prefix);
      c.last_code = 1'b1;
      add_expected(c);
      cur_prefix = '0;
      have_prefix = 1'b0;
      free_code = lzwe_pkg::FIRST_FREE;
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic eom);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    encode_byte(b, eom);
  endtask

  task automatic send_message(int len, int alphabet);
    for (int i = 0; i < len; i++)
      send_byte(alphabet >= 256 ? 8'($urandom) : 8'($urandom_range(0, alphabet - 1)),
                i == len - 1);
  endtask

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_codes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected code %0d last %0b", out_code_word, out_last_code);
      end else begin
        if (out_code_word !== pending_codes[0].code_word ||
            out_last_code !== pending_codes[0].last_code) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("code mismatch: expected %0d last %0b, got %0d last %0b",
                     pending_codes[0].code_word, pending_codes[0].last_code,
                     out_code_word, out_last_code);
        end
        void'(pending_codes.pop_front());
      end
    end
  end

  task automatic test_extremes;
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_repeats;
    // builds chains of hits on a two-letter pattern
    for (int i = 0; i < 14; i++) send_byte(i[0] ? 8'h62 : 8'h61, i == 13);
  endtask

  task automatic test_random_messages;
    int sent;
    int len;
    sent = 0;
    while (sent < 1270) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 45);
      case ($urandom_range(0, 3))
        0: send_message(len, 256);
        1: send_message(len, 2);
        default: send_message(len, $urandom_range(3, 8));
      endcase
      sent += len;
    end
  endtask

  initial begin
    int waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_end_of_message = 1'b0;
    mismatch_count = 0;
    burst_left = 0;
    cur_prefix = '0;
    have_prefix = 1'b0;
    free_code = lzwe_pkg::FIRST_FREE;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_extremes();
    test_repeats();
    test_random_messages();
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_codes.size() != 0 && waited < 200_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && pending_codes.size() == 0)
      $display("lzw_byte_encoder_test OK");
    else
      $display("lzw_byte_encoder_test NOT OK");
    $finish;
  end

endmodule
